@@ rtl/pcfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcfu_pkg;
   localparam int NSLOTS = 18;
   localparam int SLOT_W = 5;
   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 256;
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
   localparam int COL_BITS = 24;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_FRAME = 2'd1,
      OP_PIXEL = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_FOCUS_GAIN = 3'd0,
      REG_MAX_STEP   = 3'd1,
      REG_X_STEP     = 3'd2,
      REG_X_ORIGIN   = 3'd3,
      REG_Y_STEP     = 3'd4,
      REG_Y_ORIGIN   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_RUN   = 2'd1,
      ST_FRAME = 2'd2
   } state_type;

   typedef logic [SINE_SIZE-1:0][15:0] sine_table_type;

   // quarter-wave polynomial sine, Q1.14
   function automatic logic signed [15:0] sine_of(input logic [15:0] p);
      logic [1:0] quad;
      logic signed [63:0] t, t2, inner, val;
      quad = p[15:14];
      t = 64'(p[13:0]);
      if (quad[0]) t = 64'sd16384 - t;
      t2 = (t * t) >>> 14;
      inner = 64'sd10583 - ((t2 * 64'sd1306) >>> 14);
      inner = 64'sd25736 - ((t2 * inner) >>> 14);
      val = (t * inner) >>> 14;
      if (val > 64'sd16384) val = 64'sd16384;
      if (quad[1]) val = -val;
      return val[15:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int k = 0; k < SINE_SIZE; k++)
         tab[k] = sine_of(16'(k << (16 - SINE_TABLE_BITS)));
      return tab;
   endfunction

   // constant ROM, folded at elaboration
   localparam sine_table_type SINE_ROM = build_sine_table();
endpackage
`default_nettype wire

@@ rtl/pcfu_coef.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Phase/rate slots and coefficient bank; frame update walks the slots one per cycle.
module pcfu_coef (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   load,
   input  wire [pcfu_pkg::SLOT_W-1:0]            load_slot,
   input  wire [15:0]                            load_phase,
   input  wire [15:0]                            load_rate,
   input  wire                                   frame_start,
   input  wire [15:0]                            focus_gain,
   output logic                                  busy,
   output logic signed [15:0]                    coef [pcfu_pkg::NSLOTS]
);
   localparam int NS = pcfu_pkg::NSLOTS;
   logic [15:0] phase_ff [NS];
   logic [15:0] rate_ff [NS];
   logic signed [15:0] coef_ff [NS];
   logic [pcfu_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic run_ff, run_in;
   // stage 2 of the walk: sine times gain
   logic mul_v_ff;
   logic [pcfu_pkg::SLOT_W-1:0] mul_idx_ff;
   logic signed [15:0] sine_ff;
   logic [15:0] np;
   logic signed [33:0] prod;
   logic signed [33:0] sh;
   logic signed [15:0] sat;

   assign np = phase_ff[idx_ff] + rate_ff[idx_ff];
   assign prod = 34'(sine_ff) * $signed({18'd0, focus_gain});
   assign sh = prod >>> 14;
   always_comb begin
      if (sh > 34'sd32767) sat = 16'sh7fff;
      else if (sh < -34'sd32768) sat = 16'sh8000;
      else sat = sh[15:0];
   end

   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      if (frame_start) begin
         run_in = 1'b1;
         idx_in = '0;
      end else if (run_ff) begin
         if (idx_ff == pcfu_pkg::SLOT_W'(NS - 1)) run_in = 1'b0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         idx_ff <= '0;
         mul_v_ff <= 1'b0;
         for (int i = 0; i < NS; i++) coef_ff[i] <= '0;
      end else begin
         run_ff <= run_in;
         idx_ff <= idx_in;
         mul_v_ff <= run_ff;
         if (mul_v_ff) coef_ff[mul_idx_ff] <= sat;
      end
   end

   always_ff @(posedge clock) begin
      mul_idx_ff <= idx_ff;
      sine_ff <= $signed(pcfu_pkg::SINE_ROM[np[15 -: pcfu_pkg::SINE_TABLE_BITS]]);
      if (run_ff) phase_ff[idx_ff] <= np;
      else if (load && load_slot < pcfu_pkg::SLOT_W'(NS)) begin
         phase_ff[load_slot] <= load_phase;
         rate_ff[load_slot] <= load_rate;
      end
   end

   assign busy = run_ff | mul_v_ff;
   assign coef = coef_ff;
endmodule
`default_nettype wire

@@ rtl/plasma_color_field_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Plasma colour field. Words on req_ are load (opcode 0), frame (1), pixel (2)
// or none (3, dropped); only pixels return a word on rsp_. Pixels stream at one
// per clock, when not stalled by rsp_tready or an address hazard, through a six-stage
// pipeline (position, squares, products, sums, scale, limit into the output
// register). The colour memory is read as a pixel enters and written as it leaves
// the scale stage; a pixel that hits the same address as one in flight is held
// until that one has written back. A frame word waits for the pipeline to empty,
// then req_tready stays low while the coefficient walk updates one slot per cycle
// through the sine ROM and gain multiplier. After reset the colour memory is
// cleared, one entry per cycle, over all MAX_ROWS*MAX_COLS entries (65536)
// before req_tready rises.
module plasma_color_field_update (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // opcode[1:0] slot[6:2] phase_value[22:7] rate_value[38:23] row[46:39] col[54:47]
   input  wire [55:0]  req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // red[16:0] green[33:17] blue[50:34]
   output logic [55:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [2:0]   csr_index,
   input  wire [31:0]  csr_data
);
   localparam int NS = pcfu_pkg::NSLOTS;
   localparam int AW = pcfu_pkg::ADDR_W;
   localparam int CB = pcfu_pkg::COL_BITS;
   localparam int NST = 6;

   logic [15:0] focus_gain_ff;
   logic [14:0] max_step_ff;
   logic [16:0] x_step_ff, y_step_ff;
   logic signed [16:0] x_origin_ff, y_origin_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         focus_gain_ff <= 16'd14746;
         max_step_ff <= 15'd5243;
         x_step_ff <= 17'd480;
         x_origin_ff <= -17'sd6144;
         y_step_ff <= 17'd480;
         y_origin_ff <= -17'sd6144;
      end else if (csr_valid) begin
         case (pcfu_pkg::reg_index_type'(csr_index))
            pcfu_pkg::REG_FOCUS_GAIN: focus_gain_ff <= csr_data[15:0];
            pcfu_pkg::REG_MAX_STEP: max_step_ff <= csr_data[14:0];
            pcfu_pkg::REG_X_STEP: x_step_ff <= csr_data[16:0];
            pcfu_pkg::REG_X_ORIGIN: x_origin_ff <= csr_data[16:0];
            pcfu_pkg::REG_Y_STEP: y_step_ff <= csr_data[16:0];
            pcfu_pkg::REG_Y_ORIGIN: y_origin_ff <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   pcfu_pkg::opcode_type op;
   logic [4:0] f_slot;
   logic [15:0] f_phase, f_rate;
   logic [7:0] f_row, f_col;
   assign op = pcfu_pkg::opcode_type'(req_tdata[1:0]);
   assign f_slot = req_tdata[6:2];
   assign f_phase = req_tdata[22:7];
   assign f_rate = req_tdata[38:23];
   assign f_row = req_tdata[46:39];
   assign f_col = req_tdata[54:47];

   // control state
   pcfu_pkg::state_type state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic coef_busy;
   logic signed [15:0] coef [NS];

   // pipeline valid/addr per stage; the last stage is the output register
   logic v_ff [NST];
   logic [AW-1:0] a_ff [NST];
   logic adv;
   logic hazard;
   logic accept, pix_acc;

   assign adv = !v_ff[NST-1] || rsp_tready;

   // output register
   logic [50:0] rsp_ff;
   assign rsp_tvalid = v_ff[NST-1];
   assign rsp_tdata = {5'd0, rsp_ff};

   logic [AW-1:0] in_addr;
   assign in_addr = {f_row[pcfu_pkg::ROW_W-1:0], f_col[pcfu_pkg::COL_W-1:0]};

   // the output stage has already written back
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < NST - 1; i++)
         if (v_ff[i] && a_ff[i] == in_addr) hazard = 1'b1;
   end

   logic pipe_empty;
   always_comb begin
      pipe_empty = 1'b1;
      for (int i = 0; i < NST; i++) if (v_ff[i]) pipe_empty = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      req_tready = 1'b0;
      case (state_ff)
         pcfu_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW + 1)'(pcfu_pkg::DEPTH - 1)) state_in = pcfu_pkg::ST_RUN;
         end
         pcfu_pkg::ST_RUN: begin
            if (op == pcfu_pkg::OP_PIXEL) req_tready = adv && !hazard;
            else if (op == pcfu_pkg::OP_FRAME) req_tready = pipe_empty;
            else req_tready = 1'b1;
            if (req_tvalid && req_tready && op == pcfu_pkg::OP_FRAME)
               state_in = pcfu_pkg::ST_FRAME;
         end
         pcfu_pkg::ST_FRAME: begin
            if (!coef_busy) state_in = pcfu_pkg::ST_RUN;
         end
         default: state_in = pcfu_pkg::ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcfu_pkg::ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign pix_acc = accept && op == pcfu_pkg::OP_PIXEL;
   logic frame_go;
   assign frame_go = accept && op == pcfu_pkg::OP_FRAME;

   pcfu_coef u_coef (
      .clock(clock), .reset(reset),
      .load(accept && op == pcfu_pkg::OP_LOAD),
      .load_slot(f_slot), .load_phase(f_phase), .load_rate(f_rate),
      .frame_start(frame_go), .focus_gain(focus_gain_ff),
      .busy(coef_busy), .coef(coef)
   );

   // colour memory: 72-bit entries
   logic [3*CB-1:0] mem [pcfu_pkg::DEPTH];
   logic [3*CB-1:0] rd_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [3*CB-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (adv) rd_ff <= mem[in_addr];
   end

   // stage 0: positions
   logic signed [18:0] xs_ff, ys_ff;
   logic signed [26:0] xr, yr;
   logic signed [17:0] xsat, ysat;
   assign xr = 27'(x_origin_ff) + $signed({2'b0, 25'(f_row) * 25'(x_step_ff)});
   assign yr = 27'(y_origin_ff) + $signed({2'b0, 25'(f_col) * 25'(y_step_ff)});
   always_comb begin
      if (xr > 27'sd131071) xsat = 18'sd131071;
      else if (xr < -27'sd131072) xsat = -18'sd131072;
      else xsat = xr[17:0];
      if (yr > 27'sd131071) ysat = 18'sd131071;
      else if (yr < -27'sd131072) ysat = -18'sd131072;
      else ysat = yr[17:0];
   end

   logic signed [17:0] x0_ff, y0_ff;
   // stage 1: squares, old colours available
   logic signed [17:0] x1_ff, y1_ff;
   logic signed [36:0] xx1_ff, yy1_ff, xy1_ff;
   logic signed [CB-1:0] old1 [3];
   // stage 2: products of coefficients
   logic signed [55:0] p2_ff [NS];
   logic signed [CB-1:0] old2 [3], old3 [3], old4 [3];
   // stage 3: sums
   logic signed [59:0] acc3_ff [3];
   // stage 4: scale
   logic signed [39:0] sc4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) v_ff[i] <= 1'b0;
      end else begin
         if (adv) begin
            v_ff[0] <= pix_acc;
            for (int i = 1; i < NST; i++) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   logic signed [36:0] one24;
   assign one24 = 37'sd16777216;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= in_addr;
         for (int i = 1; i < NST; i++) a_ff[i] <= a_ff[i-1];
         x0_ff <= xsat;
         y0_ff <= ysat;
         x1_ff <= x0_ff;
         y1_ff <= y0_ff;
         xx1_ff <= 37'(x0_ff) * 37'(x0_ff);
         yy1_ff <= 37'(y0_ff) * 37'(y0_ff);
         xy1_ff <= 37'(x0_ff) * 37'(y0_ff);
         for (int i = 0; i < 3; i++) old1[i] <= rd_ff[i*CB +: CB];
         for (int b = 0; b < 3; b++) begin
            p2_ff[6*b]   <= 56'(coef[6*b]) * 56'($signed({x1_ff, 12'd0}));
            p2_ff[6*b+1] <= 56'(coef[6*b+1]) * 56'($signed({y1_ff, 12'd0}));
         end
         p2_ff[2]  <= 56'(coef[2]) * 56'(xx1_ff + one24);
         p2_ff[3]  <= 56'(coef[3]) * 56'(xy1_ff);
         p2_ff[4]  <= 56'(coef[4]) * 56'($signed({old1[1], 8'd0}));
         p2_ff[5]  <= 56'(coef[5]) * 56'($signed({old1[2], 8'd0}));
         p2_ff[8]  <= 56'(coef[8]) * 56'(xx1_ff);
         p2_ff[9]  <= 56'(coef[9]) * 56'(yy1_ff - one24);
         p2_ff[10] <= 56'(coef[10]) * 56'($signed({old1[0], 8'd0}));
         p2_ff[11] <= 56'(coef[11]) * 56'($signed({old1[2], 8'd0}));
         p2_ff[14] <= 56'(coef[14]) * 56'(one24 - xy1_ff);
         p2_ff[15] <= 56'(coef[15]) * 56'(yy1_ff);
         p2_ff[16] <= 56'(coef[16]) * 56'($signed({old1[0], 8'd0}));
         p2_ff[17] <= 56'(coef[17]) * 56'($signed({old1[1], 8'd0}));
         old2 <= old1;
         for (int b = 0; b < 3; b++)
            acc3_ff[b] <= 60'(p2_ff[6*b]) + 60'(p2_ff[6*b+1]) + 60'(p2_ff[6*b+2])
                        + 60'(p2_ff[6*b+3]) + 60'(p2_ff[6*b+4]) + 60'(p2_ff[6*b+5]);
         old3 <= old2;
         for (int b = 0; b < 3; b++)
            sc4_ff[b] <= 40'((50'(acc3_ff[b] >>> 22) * 50'sd45875) >>> 16);
         old4 <= old3;
      end
   end

   // stage 5: saturate, step limit, write back, magnitude
   logic signed [CB-1:0] newc [3];
   logic signed [40:0] vs, lo, hi, oc;
   logic signed [CB:0] mag [3];
   logic [16:0] outm [3];
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         oc = 41'(old4[b]);
         if (sc4_ff[b] > 40'sd8388607) vs = 41'sd8388607;
         else if (sc4_ff[b] < -40'sd8388608) vs = -41'sd8388608;
         else vs = 41'(sc4_ff[b]);
         hi = oc + 41'(max_step_ff);
         lo = oc - 41'(max_step_ff);
         if (vs > hi) vs = hi;
         if (vs < lo) vs = lo;
         newc[b] = vs[CB-1:0];
         mag[b] = newc[b][CB-1] ? -(CB + 1)'(newc[b]) : (CB + 1)'(newc[b]);
         outm[b] = (mag[b] > (CB + 1)'(65536)) ? 17'd65536 : mag[b][16:0];
      end
   end

   always_comb begin
      if (state_ff == pcfu_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = '0;
      end else begin
         wr_en = adv && v_ff[NST-2];
         wr_addr = a_ff[NST-2];
         wr_data = {newc[2], newc[1], newc[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_ff[NST-2]) rsp_ff <= {outm[2], outm[1], outm[0]};
   end
endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;

   class plasma_scoreboard;
      int             fails;
      logic [50:0]    pending_colors[$];
      int             colors[pcfu_pkg::DEPTH][3];
      logic [15:0]    phase[pcfu_pkg::NSLOTS];
      logic [15:0]    rate[pcfu_pkg::NSLOTS];
      longint         coef[pcfu_pkg::NSLOTS];
      longint         sine_q14[pcfu_pkg::SINE_SIZE];
      longint         gain, step_lim, xstep, xorg, ystep, yorg;

      function new();
         longint t, t2, in1, v;
         fails = 0;
         for (int k = 0; k < pcfu_pkg::SINE_SIZE; k++) begin
            t = (k << (16 - pcfu_pkg::SINE_TABLE_BITS)) & 16'h3fff;
            if ((k >> (pcfu_pkg::SINE_TABLE_BITS - 2)) & 1) t = 16384 - t;
            t2 = (t * t) >>> 14;
            in1 = 10583 - ((t2 * 1306) >>> 14);
            in1 = 25736 - ((t2 * in1) >>> 14);
            v = (t * in1) >>> 14;
            if (v > 16384) v = 16384;
            sine_q14[k] = ((k >> (pcfu_pkg::SINE_TABLE_BITS - 1)) & 1) ? -v : v;
         end
         for (int a = 0; a < pcfu_pkg::DEPTH; a++)
            for (int j = 0; j < 3; j++) colors[a][j] = 0;
         for (int i = 0; i < pcfu_pkg::NSLOTS; i++) begin
            phase[i] = 0; rate[i] = 0; coef[i] = 0;
         end
         gain = 14746; step_lim = 5243; xstep = 480; xorg = -6144; ystep = 480; yorg = -6144;
      endfunction

      function void set_reg(pcfu_pkg::reg_index_type idx, logic [31:0] d);
         case (idx)
            pcfu_pkg::REG_FOCUS_GAIN: gain = d[15:0];
            pcfu_pkg::REG_MAX_STEP:   step_lim = d[14:0];
            pcfu_pkg::REG_X_STEP:     xstep = d[16:0];
            pcfu_pkg::REG_X_ORIGIN:   xorg = longint'(signed'(d[16:0]));
            pcfu_pkg::REG_Y_STEP:     ystep = d[16:0];
            pcfu_pkg::REG_Y_ORIGIN:   yorg = longint'(signed'(d[16:0]));
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void note_word(logic [55:0] w);
         pcfu_pkg::opcode_type op;
         longint x, y, xx, yy, xy, v, m;
         longint old[3], acc[3];
         logic [16:0] mag[3];
         int addr;
         op = pcfu_pkg::opcode_type'(w[1:0]);
         case (op)
            pcfu_pkg::OP_LOAD: if (w[6:2] < pcfu_pkg::NSLOTS) begin
               phase[w[6:2]] = w[22:7];
               rate[w[6:2]] = w[38:23];
            end
            pcfu_pkg::OP_FRAME: for (int i = 0; i < pcfu_pkg::NSLOTS; i++) begin
               phase[i] = phase[i] + rate[i];
               coef[i] = clip((sine_q14[phase[i] >> (16 - pcfu_pkg::SINE_TABLE_BITS)] * gain)
                              >>> 14, -32768, 32767);
            end
            pcfu_pkg::OP_PIXEL: begin
               addr = (w[46:39] % pcfu_pkg::MAX_ROWS) * pcfu_pkg::MAX_COLS
                    + (w[54:47] % pcfu_pkg::MAX_COLS);
               x = clip(xorg + longint'(w[46:39]) * xstep, -131072, 131071);
               y = clip(yorg + longint'(w[54:47]) * ystep, -131072, 131071);
               xx = x * x; yy = y * y; xy = x * y;
               for (int j = 0; j < 3; j++) old[j] = colors[addr][j];
               acc[0] = coef[0]*x*4096 + coef[1]*y*4096 + coef[2]*(xx + 64'sd16777216)
                      + coef[3]*xy + coef[4]*old[1]*256 + coef[5]*old[2]*256;
               acc[1] = coef[6]*x*4096 + coef[7]*y*4096 + coef[8]*xx
                      + coef[9]*(yy - 64'sd16777216) + coef[10]*old[0]*256
                      + coef[11]*old[2]*256;
               acc[2] = coef[12]*x*4096 + coef[13]*y*4096 + coef[14]*(64'sd16777216 - xy)
                      + coef[15]*yy + coef[16]*old[0]*256 + coef[17]*old[1]*256;
               for (int j = 0; j < 3; j++) begin
                  v = ((acc[j] >>> 22) * 45875) >>> 16;
                  v = clip(v, -8388608, 8388607);
                  v = clip(v, old[j] - step_lim, old[j] + step_lim);
                  colors[addr][j] = int'(v);
                  m = v < 0 ? -v : v;
                  mag[j] = m > 65536 ? 17'd65536 : m[16:0];
               end
               pending_colors.push_back({mag[2], mag[1], mag[0]});
            end
            default: ;  // unused opcode is dropped
         endcase
      endfunction

      function void check_word(logic [55:0] d);
         logic [50:0] e;
         if (pending_colors.size() == 0) begin
            $display("%0t unexpected result word %h", $time, d);
            fails++;
            return;
         end
         e = pending_colors.pop_front();
         if (d[16:0] !== e[16:0]) begin
            $display("%0t red exp %0d got %0d", $time, e[16:0], d[16:0]); fails++;
         end
         if (d[33:17] !== e[33:17]) begin
            $display("%0t green exp %0d got %0d", $time, e[33:17], d[33:17]); fails++;
         end
         if (d[50:34] !== e[50:34]) begin
            $display("%0t blue exp %0d got %0d", $time, e[50:34], d[50:34]); fails++;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [55:0] req_tdata = '0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   wire         req_tready, rsp_tvalid, csr_ready;
   wire  [55:0] rsp_tdata;
   bit          quiet = 0;
   int          stall_left = 0;
   longint      cycles = 0;
   plasma_scoreboard sb = new();

   plasma_color_field_update dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 0;
      end else begin
         rsp_tready = 1;
         if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);

   function automatic logic [55:0] pack(pcfu_pkg::opcode_type op, logic [4:0] s,
                                        logic [15:0] ph, logic [15:0] rt,
                                        logic [7:0] r, logic [7:0] c);
      return {1'b0, c, r, rt, ph, s, op};
   endfunction

   task automatic send_word(logic [55:0] w);
      req_tdata = w;
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(w);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // block must be drained, including a frame walk that yields no word
   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.pending_colors.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(pcfu_pkg::reg_index_type idx, longint val);
      csr_index = idx;
      csr_data = 32'(val);
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, 32'(val));
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_words(int n, int quiet_tail);
      int pick;
      logic [7:0] r, c;
      for (int i = 0; i < n; i++) begin
         if (i == n - quiet_tail) quiet = 1;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) < 6) begin
            r = 8'($urandom_range(0, 3)); c = 8'($urandom_range(0, 3));
         end else begin
            r = 8'($urandom); c = 8'($urandom);
         end
         send_word(pack(pick < 85 ? pcfu_pkg::OP_PIXEL : pick < 92 ? pcfu_pkg::OP_FRAME
                        : pick < 97 ? pcfu_pkg::OP_LOAD : pcfu_pkg::OP_NONE,
                        5'($urandom), 16'($urandom), 16'($urandom), r, c));
      end
   endtask

   initial begin
      longint cfg[4][6];
      cfg[0] = '{5243, 262, 0, -65536, 0, -65536};
      cfg[1] = '{37683, 26214, 131071, 65535, 131071, 65535};
      cfg[2] = '{$urandom_range(5243, 37683), $urandom_range(262, 26214),
                 $urandom_range(0, 2000), longint'($urandom_range(0, 131071)) - 65536,
                 $urandom_range(0, 2000), longint'($urandom_range(0, 131071)) - 65536};
      cfg[3] = '{$urandom_range(5243, 37683), $urandom_range(262, 26214),
                 $urandom_range(0, 131071), longint'($urandom_range(0, 131071)) - 65536,
                 $urandom_range(0, 131071), longint'($urandom_range(0, 131071)) - 65536};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // every slot loaded before any frame, extremes of phase and rate
      for (int s = 0; s < pcfu_pkg::NSLOTS; s++)
         send_word(pack(pcfu_pkg::OP_LOAD, 5'(s), s[0] ? 16'hffff : 16'h0000,
                        s[1] ? 16'hffff : 16'h0000, 8'(s), 8'(255 - s)));
      // out of range slots
      send_word(pack(pcfu_pkg::OP_LOAD, 5'd18, 16'h1234, 16'h4321, 8'd0, 8'd0));
      send_word(pack(pcfu_pkg::OP_LOAD, 5'd31, 16'hffff, 16'hffff, 8'd0, 8'd0));
      send_word(pack(pcfu_pkg::OP_NONE, 5'd31, 16'hffff, 16'hffff, 8'hff, 8'hff));
      send_word(pack(pcfu_pkg::OP_PIXEL, 5'd0, 16'd0, 16'd0, 8'd0, 8'd0));
      send_word(pack(pcfu_pkg::OP_FRAME, 5'd0, 16'd0, 16'd0, 8'd0, 8'd0));
      send_word(pack(pcfu_pkg::OP_PIXEL, 5'd0, 16'd0, 16'd0, 8'hff, 8'hff));
      // back-to-back same address
      send_word(pack(pcfu_pkg::OP_PIXEL, 5'd0, 16'd0, 16'd0, 8'hff, 8'hff));
      send_word(pack(pcfu_pkg::OP_PIXEL, 5'd0, 16'd0, 16'd0, 8'd0, 8'hff));
      send_word(pack(pcfu_pkg::OP_PIXEL, 5'd0, 16'd0, 16'd0, 8'hff, 8'd0));
      random_words(200, 0);

      for (int p = 0; p < 4; p++) begin
         drain();
         for (int k = 0; k < 6; k++) write_reg(pcfu_pkg::reg_index_type'(k), cfg[p][k]);
         random_words(220, p == 3 ? 150 : 0);
      end

      drain();
      repeat (50) @(negedge clock);
      if (sb.fails == 0 && sb.pending_colors.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
